// ===== hw/rtl/vsm_pkg.sv =====
// shared widths, register codes and pipeline types for the sphere morph step block
`default_nettype none

package vsm_pkg;

	// word format
	localparam int CW    = 32;          // coordinate word width
	localparam int FB    = 16;          // fraction bits
	localparam int NLANE = 3;           // x, y, z
	localparam int NOUT  = 2 * NLANE;   // position and normal deltas

	// derived datapath widths
	localparam int AW  = CW + 1;        // offset from center, signed, and its magnitude
	localparam int SW  = 2 * AW + 2;    // sum of three squares
	localparam int LW  = AW + 1;        // root of the sum
	localparam int RW  = CW - 1;        // radius width and radial quotient width
	localparam int NW  = RW + AW;       // radial numerator width
	localparam int QU  = FB + 1;        // unit quotient width
	localparam int PW  = CW + 3;        // pre-scale delta width
	localparam int SCW = 16;            // step count width
	localparam int HW  = SCW - 1;       // half step count width

	// configuration register index
	localparam int CIW = 3;
	typedef enum logic [CIW-1:0] {
		REG_OWN_X,
		REG_OWN_Y,
		REG_OWN_Z,
		REG_TGT_X,
		REG_TGT_Y,
		REG_TGT_Z,
		REG_RADIUS,
		REG_STEPS
	} cfg_reg_t;

	// reset values: radius 10.0, 100 steps
	localparam logic [RW-1:0]  RADIUS_RST = RW'(10) << FB;
	localparam logic [SCW-1:0] STEPS_RST  = SCW'(100);

	// per-vertex data carried alongside the root and length division
	typedef struct packed {
		logic                        zero;
		logic [NLANE-1:0]            neg;
		logic [NLANE-1:0][AW-1:0]    mag;
		logic [NLANE-1:0][NW-1:0]    rnum;
		logic [NLANE-1:0][CW-1:0]    norm;
	} vtx_t;

endpackage

`default_nettype wire

// ===== hw/rtl/vsm_isqrt.sv =====
// pipelined integer square root, one root bit per stage, with sideband
`default_nettype none

module vsm_isqrt import vsm_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_v,
	input  logic [SW-1:0] in_s,
	input  vtx_t          in_x,
	output logic          out_v,
	output logic [LW-1:0] out_root,
	output vtx_t          out_x
);

	logic          v_s    [LW];
	logic [SW-1:0] rem_s  [LW];
	logic [LW-1:0] root_s [LW];
	vtx_t          x_s    [LW];

	for (genvar k = 0; k < LW; k++) begin : g_stg
		localparam int B = LW - 1 - k;

		logic          pv;
		logic [SW-1:0] prem;
		logic [LW-1:0] proot;
		vtx_t          px;
		logic [SW:0]   cand;
		logic          take;

		if (k == 0) begin : g_first
			assign pv    = in_v;
			assign prem  = in_s;
			assign proot = '0;
			assign px    = in_x;
		end else begin : g_next
			assign pv    = v_s[k-1];
			assign prem  = rem_s[k-1];
			assign proot = root_s[k-1];
			assign px    = x_s[k-1];
		end

		// (r + 2^b)^2 - r^2, the bits of r and 2^2b never overlap
		assign cand = ({{(SW + 1 - LW){1'b0}}, proot} << (B + 1)) |
		              ({{SW{1'b0}}, 1'b1} << (2 * B));
		assign take = {1'b0, prem} >= cand;

		// stage valid
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= pv;
			end
		end

		// remainder and root
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= take ? prem - cand[SW-1:0] : prem;
				root_s[k] <= take ? (proot | (LW'(1) << B)) : proot;
				x_s[k]    <= px;
			end
		end
	end

	assign out_v    = v_s[LW-1];
	assign out_root = root_s[LW-1];
	assign out_x    = x_s[LW-1];

endmodule

`default_nettype wire

// ===== hw/rtl/vsm_ldiv.sv =====
// pipelined restoring division of radial and unit numerators by the offset length
`default_nettype none

module vsm_ldiv import vsm_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_v,
	input  logic [LW-1:0]             in_len,
	input  vtx_t                      in_x,
	output logic                      out_v,
	output logic [NLANE-1:0][RW-1:0]  out_qr,
	output logic [NLANE-1:0][QU-1:0]  out_qu,
	output vtx_t                      out_x
);

	logic                     v_s   [RW];
	logic [LW-1:0]            len_s [RW];
	logic [NLANE-1:0][NW-1:0] rr_s  [RW];
	logic [NLANE-1:0][NW-1:0] ru_s  [RW];
	logic [NLANE-1:0][RW-1:0] qr_s  [RW];
	logic [NLANE-1:0][QU-1:0] qu_s  [RW];
	vtx_t                     x_s   [RW];

	for (genvar k = 0; k < RW; k++) begin : g_stg
		localparam int B = RW - 1 - k;

		logic                     pv;
		logic [LW-1:0]            plen;
		logic [NLANE-1:0][NW-1:0] prr, pru, nrr, nru;
		logic [NLANE-1:0][RW-1:0] pqr, nqr;
		logic [NLANE-1:0][QU-1:0] pqu, nqu;
		vtx_t                     px;
		logic [NW:0]              dsh;

		if (k == 0) begin : g_first
			assign pv   = in_v;
			assign plen = in_len;
			assign pqr  = '0;
			assign pqu  = '0;
			// numerators R*|d| and |d| scaled to the word format
			always_comb begin
				px      = in_x;
				px.zero = (in_len == '0);
				for (int i = 0; i < NLANE; i++) begin
					prr[i] = in_x.rnum[i];
					pru[i] = NW'(in_x.mag[i]) << FB;
				end
			end
		end else begin : g_next
			assign pv   = v_s[k-1];
			assign plen = len_s[k-1];
			assign prr  = rr_s[k-1];
			assign pru  = ru_s[k-1];
			assign pqr  = qr_s[k-1];
			assign pqu  = qu_s[k-1];
			assign px   = x_s[k-1];
		end

		assign dsh = {{(NW + 1 - LW){1'b0}}, plen} << B;

		// one quotient bit per lane; the unit quotient is narrower
		always_comb begin
			for (int i = 0; i < NLANE; i++) begin
				nrr[i] = prr[i];
				nqr[i] = pqr[i];
				nru[i] = pru[i];
				nqu[i] = pqu[i];
				if ({1'b0, prr[i]} >= dsh) begin
					nrr[i] = prr[i] - dsh[NW-1:0];
					nqr[i] = pqr[i] | (RW'(1) << B);
				end
				if (B < QU) begin
					if ({1'b0, pru[i]} >= dsh) begin
						nru[i] = pru[i] - dsh[NW-1:0];
						nqu[i] = pqu[i] | (QU'(1) << B);
					end
				end
			end
		end

		// stage valid
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= pv;
			end
		end

		// stage payload
		always_ff @(posedge clk) begin
			if (en) begin
				len_s[k] <= plen;
				rr_s[k]  <= nrr;
				ru_s[k]  <= nru;
				qr_s[k]  <= nqr;
				qu_s[k]  <= nqu;
				x_s[k]   <= px;
			end
		end
	end

	assign out_v  = v_s[RW-1];
	assign out_qr = qr_s[RW-1];
	assign out_qu = qu_s[RW-1];
	assign out_x  = x_s[RW-1];

endmodule

`default_nettype wire

// ===== hw/rtl/vertex_sphere_morph_step_core.sv =====
// top level of the sphere morph step block: config, front end, scale by half steps, output
//
// Per vertex, gives the per-step position and normal increments that move it onto a sphere.
// Input stream s_axis: one word per vertex, position and normal in Q16.16.
// Output stream m_axis: one word per vertex, six deltas; tuser flags a vertex on the center,
// in which case every delta is zero.
// Config port: cfg_we writes cfg_data into register cfg_index on a rising edge; write only
// while no vertex is in flight. Centers, radius and step count come from the host.
// Throughput: one vertex per cycle while the skid word is empty. A vertex passes through the
// 34-stage square root, the 31-stage length divider and the 35-stage divider by half the step
// count, each resolving one bit per stage, plus front end and output stages.
// A stall on m_axis freezes the whole pipeline once the skid word is full; a two-entry
// output register and skid word take what is in flight, and s_axis_tready is the registered
// skid-empty flag, so an item still enters while a finished word waits.
// Reset clears all valid bits and loads centers 0, radius 10.0 and 100 steps.
`default_nettype none

module vertex_sphere_morph_step_core import vsm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// configuration write port
	input  logic               cfg_we,
	input  logic [CIW-1:0]     cfg_index,
	input  logic [CW-1:0]      cfg_data,
	// vertex input
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [6*CW-1:0]    s_axis_tdata,   // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z
	// delta output
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [6*CW-1:0]    m_axis_tdata,   // delta_x/y/z, ndelta_x/y/z
	output logic               m_axis_tuser    // zero_length
);

	// configuration registers
	logic [NLANE-1:0][CW-1:0] oc_q;
	logic [NLANE-1:0][CW-1:0] tc_q;
	logic [RW-1:0]            radius_q;
	logic [SCW-1:0]           steps_q;
	logic [NLANE-1:0][AW-1:0] ofs_q;
	logic [HW-1:0]            half_q;

	logic en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oc_q     <= '0;
			tc_q     <= '0;
			radius_q <= RADIUS_RST;
			steps_q  <= STEPS_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_OWN_X:  oc_q[0]  <= cfg_data;
				REG_OWN_Y:  oc_q[1]  <= cfg_data;
				REG_OWN_Z:  oc_q[2]  <= cfg_data;
				REG_TGT_X:  tc_q[0]  <= cfg_data;
				REG_TGT_Y:  tc_q[1]  <= cfg_data;
				REG_TGT_Z:  tc_q[2]  <= cfg_data;
				REG_RADIUS: radius_q <= cfg_data[RW-1:0];
				REG_STEPS:  steps_q  <= cfg_data[SCW-1:0];
				default:    ;
			endcase
		end
	end

	// center shift and half step count, settled long before a vertex needs them
	always_ff @(posedge clk) begin
		for (int i = 0; i < NLANE; i++) begin
			ofs_q[i] <= {tc_q[i][CW-1], tc_q[i]} - {oc_q[i][CW-1], oc_q[i]};
		end
		half_q <= (steps_q[SCW-1:1] == '0) ? HW'(1) : steps_q[SCW-1:1];
	end

	// stage 1: offset from own center
	logic                     v_s1;
	logic [NLANE-1:0][AW-1:0] d_s1;
	logic [NLANE-1:0][CW-1:0] n_s1;

	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NLANE; i++) begin
				d_s1[i] <= {s_axis_tdata[i*CW + CW - 1], s_axis_tdata[i*CW +: CW]} -
				           {oc_q[i][CW-1], oc_q[i]};
				n_s1[i] <= s_axis_tdata[(NLANE + i)*CW +: CW];
			end
		end
	end

	// stage 2: sign and magnitude
	logic v_s2;
	vtx_t x_s2, x2_d;

	always_comb begin
		x2_d      = '0;
		x2_d.norm = n_s1;
		for (int i = 0; i < NLANE; i++) begin
			x2_d.neg[i] = d_s1[i][AW-1];
			x2_d.mag[i] = d_s1[i][AW-1] ? -d_s1[i] : d_s1[i];
		end
	end

	// stage 3: squares and radial numerators
	logic                       v_s3;
	vtx_t                       x_s3, x3_d;
	logic [NLANE-1:0][2*AW-1:0] sq_s3;

	always_comb begin
		x3_d = x_s2;
		for (int i = 0; i < NLANE; i++) begin
			x3_d.rnum[i] = radius_q * x_s2.mag[i];
		end
	end

	// stage 4: sum of squares
	logic          v_s4;
	vtx_t          x_s4;
	logic [SW-1:0] sum_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s2 <= x2_d;
			x_s3 <= x3_d;
			for (int i = 0; i < NLANE; i++) begin
				sq_s3[i] <= x_s2.mag[i] * x_s2.mag[i];
			end
			x_s4   <= x_s3;
			sum_s4 <= SW'(sq_s3[0]) + SW'(sq_s3[1]) + SW'(sq_s3[2]);
		end
	end

	// length
	logic          rt_v;
	logic [LW-1:0] rt_len;
	vtx_t          rt_x;

	vsm_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_v     (v_s4),
		.in_s     (sum_s4),
		.in_x     (x_s4),
		.out_v    (rt_v),
		.out_root (rt_len),
		.out_x    (rt_x)
	);

	// radial and unit terms
	logic                     dv_v;
	logic [NLANE-1:0][RW-1:0] dv_qr;
	logic [NLANE-1:0][QU-1:0] dv_qu;
	vtx_t                     dv_x;

	vsm_ldiv u_ldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (rt_v),
		.in_len (rt_len),
		.in_x   (rt_x),
		.out_v  (dv_v),
		.out_qr (dv_qr),
		.out_qu (dv_qu),
		.out_x  (dv_x)
	);

	// stage 5: unscaled position and normal deltas
	logic                    v_s5, zero_s5;
	logic [NOUT-1:0][PW-1:0] val_s5, val_d;

	always_comb begin
		logic [PW-1:0] rad, unit, dd;
		for (int i = 0; i < NLANE; i++) begin
			rad  = dv_x.neg[i] ? -PW'(dv_qr[i]) : PW'(dv_qr[i]);
			unit = dv_x.neg[i] ? -PW'(dv_qu[i]) : PW'(dv_qu[i]);
			dd   = dv_x.neg[i] ? -PW'(dv_x.mag[i]) : PW'(dv_x.mag[i]);
			val_d[i] = rad - dd + {{(PW - AW){ofs_q[i][AW-1]}}, ofs_q[i]};
			val_d[NLANE + i] = unit - {{(PW - CW){dv_x.norm[i][CW-1]}}, dv_x.norm[i]};
		end
	end

	// stage 6: sign and magnitude for the scale division
	logic                    v_s6, zero_s6;
	logic [NOUT-1:0]         neg_s6;
	logic [NOUT-1:0][PW-1:0] mag_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s5 <= dv_v;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s5 <= dv_x.zero;
			val_s5  <= val_d;
			zero_s6 <= zero_s5;
			for (int l = 0; l < NOUT; l++) begin
				neg_s6[l] <= val_s5[l][PW-1];
				mag_s6[l] <= val_s5[l][PW-1] ? -val_s5[l] : val_s5[l];
			end
		end
	end

	// division by half the step count, one quotient bit per stage
	logic                    hv_s    [PW];
	logic                    hzero_s [PW];
	logic [NOUT-1:0]         hneg_s  [PW];
	logic [NOUT-1:0][PW-1:0] hrem_s  [PW];
	logic [NOUT-1:0][PW-1:0] hq_s    [PW];

	for (genvar k = 0; k < PW; k++) begin : g_hdiv
		localparam int B = PW - 1 - k;

		logic                    pv, pzero;
		logic [NOUT-1:0]         pneg;
		logic [NOUT-1:0][PW-1:0] prem, pq, nrem, nq;
		logic [HW+PW-1:0]        dsh;

		if (k == 0) begin : g_first
			assign pv    = v_s6;
			assign pzero = zero_s6;
			assign pneg  = neg_s6;
			assign prem  = mag_s6;
			assign pq    = '0;
		end else begin : g_next
			assign pv    = hv_s[k-1];
			assign pzero = hzero_s[k-1];
			assign pneg  = hneg_s[k-1];
			assign prem  = hrem_s[k-1];
			assign pq    = hq_s[k-1];
		end

		assign dsh = {{PW{1'b0}}, half_q} << B;

		always_comb begin
			for (int l = 0; l < NOUT; l++) begin
				nrem[l] = prem[l];
				nq[l]   = pq[l];
				if ({{HW{1'b0}}, prem[l]} >= dsh) begin
					nrem[l] = prem[l] - dsh[PW-1:0];
					nq[l]   = pq[l] | (PW'(1) << B);
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				hv_s[k] <= 1'b0;
			end else if (en) begin
				hv_s[k] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				hzero_s[k] <= pzero;
				hneg_s[k]  <= pneg;
				hrem_s[k]  <= nrem;
				hq_s[k]    <= nq;
			end
		end
	end

	// saturate, restore sign, force zero for a vertex on the center
	localparam logic [PW-1:0] POS_LIM = PW'({1'b0, {(CW - 1){1'b1}}});
	localparam logic [PW-1:0] NEG_LIM = PW'({1'b1, {(CW - 1){1'b0}}});

	logic                    fin_v;
	logic                    fin_zero;
	logic [NOUT-1:0][CW-1:0] fin_data;

	assign fin_v    = hv_s[PW-1];
	assign fin_zero = hzero_s[PW-1];

	always_comb begin
		logic [PW-1:0] q;
		for (int l = 0; l < NOUT; l++) begin
			q = hq_s[PW-1][l];
			if (fin_zero) begin
				fin_data[l] = '0;
			end else if (hneg_s[PW-1][l]) begin
				fin_data[l] = (q > NEG_LIM) ? NEG_LIM[CW-1:0] : -q[CW-1:0];
			end else begin
				fin_data[l] = (q > POS_LIM) ? POS_LIM[CW-1:0] : q[CW-1:0];
			end
		end
	end

	// output word and skid word
	logic                    out_v_q, skid_v_q;
	logic                    out_zero_q, skid_zero_q;
	logic [NOUT-1:0][CW-1:0] out_data_q, skid_data_q;

	assign en = !skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (m_axis_tready) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end
		end else if (out_v_q && !m_axis_tready) begin
			skid_v_q <= fin_v;
		end else begin
			out_v_q <= fin_v;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (m_axis_tready) begin
				out_data_q <= skid_data_q;
				out_zero_q <= skid_zero_q;
			end
		end else if (out_v_q && !m_axis_tready) begin
			skid_data_q <= fin_data;
			skid_zero_q <= fin_zero;
		end else begin
			out_data_q <= fin_data;
			out_zero_q <= fin_zero;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_zero_q;

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// testbench for the sphere morph step block: directed table, random vertices, predictor check
`timescale 1ns / 1ps
`default_nettype none

module tb;
	import vsm_pkg::*;

	localparam int LATENCY   = 106;
	localparam int MAX_CYC   = 2000000;
	localparam int N_RANDOM  = 500;
	localparam int N_DIRECT  = 14;

	// one output word as the block presents it
	typedef struct packed {
		logic            zero;
		logic [CW*6-1:0] data;
	} delta_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CIW-1:0] cfg_index = '0;
	logic [CW-1:0] cfg_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [6*CW-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [6*CW-1:0] m_axis_tdata;
	logic m_axis_tuser;

	vertex_sphere_morph_step_core dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	always #6 clk = ~clk;

	// predictor copy of the registers
	logic signed [CW-1:0] own_c [3];
	logic signed [CW-1:0] tgt_c [3];
	logic [RW-1:0] radius;
	logic [15:0] steps;

	delta_word_t delta_q[$];
	int errors = 0;
	int cycles = 0;
	bit no_idle = 0;

	// truncating divide by half steps, saturated to a word
	function automatic logic [CW-1:0] scale_sat(logic signed [127:0] v, logic [15:0] half);
		logic [127:0] mag;
		logic signed [127:0] q;
		mag = v < 0 ? -v : v;
		q = mag / half;
		if (v < 0) q = -q;
		if (q > 128'sd2147483647) q = 128'sd2147483647;
		if (q < -128'sd2147483648) q = -128'sd2147483648;
		return q[CW-1:0];
	endfunction

	function automatic delta_word_t morph_delta(logic [6*CW-1:0] vtx);
		delta_word_t r;
		logic signed [63:0] d [3];
		logic [63:0] a [3];
		logic [127:0] s, len, t, qr, qu;
		logic [15:0] half;
		logic signed [127:0] p, nv;
		logic signed [CW-1:0] pin, nin;
		half = steps >> 1;
		if (half == 0) half = 1;
		s = 0;
		for (int i = 0; i < 3; i++) begin
			pin = vtx[i*CW +: CW];
			d[i] = 64'(pin) - 64'(own_c[i]);
			a[i] = d[i] < 0 ? -d[i] : d[i];
			s += 128'(a[i]) * 128'(a[i]);
		end
		// bitwise integer square root
		len = 0;
		for (int b = 51; b >= 0; b--) begin
			t = len | (128'd1 << b);
			if (t * t <= s) len = t;
		end
		r = '0;
		if (len == 0) begin
			r.zero = 1'b1;
			return r;
		end
		for (int i = 0; i < 3; i++) begin
			nin = vtx[(3+i)*CW +: CW];
			qr = (128'(radius) * 128'(a[i])) / len;
			if (qr > (128'd1 << 62)) qr = 128'd1 << 62;
			qu = (128'(a[i]) << FB) / len;
			p = (d[i] < 0 ? -$signed(qr) : $signed(qr)) - 128'(d[i])
				+ 128'(tgt_c[i]) - 128'(own_c[i]);
			nv = (d[i] < 0 ? -$signed(qu) : $signed(qu)) - 128'(nin);
			r.data[i*CW +: CW] = scale_sat(p, half);
			r.data[(3+i)*CW +: CW] = scale_sat(nv, half);
		end
		return r;
	endfunction

	// one write, then a wait with the enable low so the enable drops between writes
	task automatic write_reg(cfg_reg_t idx, logic [CW-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_OWN_X, REG_OWN_Y, REG_OWN_Z: own_c[idx - REG_OWN_X] = val;
			REG_TGT_X, REG_TGT_Y, REG_TGT_Z: tgt_c[idx - REG_TGT_X] = val;
			REG_RADIUS: radius = val[RW-1:0];
			default: steps = val[15:0];
		endcase
		@(posedge clk);
	endtask

	task automatic drain;
		s_axis_tvalid <= 1'b0;
		while (delta_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	// send one vertex, optionally with a typed expectation; tvalid stays up afterwards
	task automatic send_vertex(logic [6*CW-1:0] vtx, bit typed, delta_word_t want);
		while (!no_idle && $urandom_range(99) < 29) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= vtx;
		delta_q.insert(delta_q.size(), typed ? want : morph_delta(vtx));
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	function automatic logic [CW-1:0] rnd_coord();
		case ($urandom_range(3))
			0: return $urandom();
			1: return $urandom_range(0, 32'h000f_ffff) - 32'h0008_0000;
			2: return {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom())};
			default: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
		endcase
	endfunction

	// receiver with random stall, compares against oldest expectation
	always @(posedge clk) begin
		delta_word_t want;
		cycles <= cycles + 1;
		m_axis_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 29);
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (delta_q.size() == 0) begin
				errors = errors + 1;
				if (errors <= 10) $display("unexpected word %h", m_axis_tdata);
			end else begin
				want = delta_q.pop_front();
				if (want.data !== m_axis_tdata || want.zero !== m_axis_tuser) begin
					errors = errors + 1;
					if (errors <= 10)
						$display("mismatch exp %h/%b got %h/%b", want.data, want.zero,
							m_axis_tdata, m_axis_tuser);
				end
			end
		end
	end

	// timeout watchdog
	always @(posedge clk) begin
		if (cycles > MAX_CYC) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	// directed vertex table
	logic [6*CW-1:0] dir_vtx [N_DIRECT];

	initial begin
		delta_word_t zw;
		logic [CW-1:0] x;
		logic [6*CW-1:0] rv;
		zw = '0;
		zw.zero = 1'b1;
		rv = '0;
		for (int i = 0; i < 3; i++) begin
			own_c[i] = 0;
			tgt_c[i] = 0;
		end
		radius = RADIUS_RST;
		steps = STEPS_RST;
		dir_vtx[0]  = '0;
		dir_vtx[1]  = {96'h0, 32'h0, 32'h0, 32'h0001_0000};
		dir_vtx[2]  = {96'h0, 32'h0, 32'h0, 32'h0000_0001};
		dir_vtx[3]  = {{3{32'h7fff_ffff}}, {3{32'h7fff_ffff}}};
		dir_vtx[4]  = {{3{32'h8000_0000}}, {3{32'h8000_0000}}};
		dir_vtx[5]  = {{3{32'h8000_0000}}, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000};
		dir_vtx[6]  = {96'h0, 32'h0, 32'hffff_ffff, 32'h0};
		dir_vtx[7]  = {32'h0001_0000, 64'h0, 32'h0003_0000, 32'h0, 32'hfffc_0000};
		dir_vtx[8]  = {96'hffff_ffff_ffff_ffff_ffff_ffff, 32'h0002_0000, 64'h0};
		dir_vtx[9]  = {96'h0, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001};
		dir_vtx[10] = {96'h0, 32'h7fff_ffff, 32'h0, 32'h0};
		dir_vtx[11] = {96'h0, 32'h0, 32'h8000_0000, 32'h0};
		dir_vtx[12] = {96'h0, 32'h1234_5678, 32'hedcb_a988, 32'h0000_0010};
		dir_vtx[13] = {{3{32'h5555_5555}}, {3{32'haaaa_aaaa}}};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows at reset settings; zero vector is typed in
		for (int i = 0; i < N_DIRECT; i++)
			send_vertex(dir_vtx[i], i == 0, zw);
		drain();

		// extreme settings: huge, zero and tiny radius, shortest and longest step counts, far centers
		write_reg(REG_RADIUS, 32'h7fff_ffff);
		write_reg(REG_STEPS, 32'd1);
		write_reg(REG_OWN_X, 32'h8000_0000);
		write_reg(REG_OWN_Y, 32'h7fff_ffff);
		write_reg(REG_OWN_Z, 32'h0);
		write_reg(REG_TGT_X, 32'h7fff_ffff);
		write_reg(REG_TGT_Y, 32'h8000_0000);
		write_reg(REG_TGT_Z, 32'h0001_0000);
		// vertex on own center gives zero flag
		send_vertex({96'h0, 32'h0, 32'h7fff_ffff, 32'h8000_0000}, 1'b1, zw);
		for (int i = 0; i < 8; i++) send_vertex(dir_vtx[i + 3], 1'b0, zw);
		drain();
		write_reg(REG_STEPS, 32'd0);
		write_reg(REG_RADIUS, 32'h0);
		for (int i = 0; i < 6; i++) send_vertex(dir_vtx[i + 5], 1'b0, zw);
		drain();
		write_reg(REG_STEPS, 32'h0000_ffff);
		write_reg(REG_RADIUS, 32'h0000_0001);
		for (int i = 0; i < 6; i++) send_vertex(dir_vtx[i + 8], 1'b0, zw);
		drain();

		// random phases with fresh settings
		for (int ph = 0; ph < 5; ph++) begin
			for (int r = 0; r < 3; r++) begin
				write_reg(cfg_reg_t'(REG_OWN_X + r), rnd_coord());
				write_reg(cfg_reg_t'(REG_TGT_X + r), rnd_coord());
			end
			write_reg(REG_RADIUS, $urandom_range(1) ? $urandom() : $urandom_range(0, 32'h00ff_ffff));
			write_reg(REG_STEPS, ph == 4 ? 32'd2 : 32'($urandom_range(2, 65535)));
			no_idle = (ph == 2);
			for (int n = 0; n < N_RANDOM / 5; n++) begin
				for (int k = 0; k < 6; k++) begin
					x = rnd_coord();
					if (k < 3 && $urandom_range(19) == 0) x = own_c[k];
					if (k < 3 && $urandom_range(9) == 0) x = own_c[k] + $urandom_range(3) - 1;
					rv[k*CW +: CW] = x;
				end
				send_vertex(rv, 1'b0, zw);
				// pause once until everything has come out
				if (n == 50 && ph == 1) begin
					s_axis_tvalid <= 1'b0;
					while (delta_q.size() != 0) @(posedge clk);
				end
			end
			drain();
		end
		no_idle = 0;

		if (errors == 0 && delta_q.size() == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule

`default_nettype wire
